// ----- rtl/rra_pkg.sv -----
// Shared constants, types and codes of the receive-ring ARP responder.
package rra_pkg;

    // Ring geometry and transmit slots
    localparam int RING_BYTES = 8192;
    localparam int RING_PAD   = 16;
    localparam int TX_SLOTS   = 4;
    localparam int RING_MOD   = RING_BYTES + RING_PAD;
    localparam int OFS_W      = $clog2(RING_MOD);
    // offset + length + 7 before reduction
    localparam int ACC_W      = $clog2(RING_MOD + 65535 + 7);
    localparam int SLOT_W     = 2;

    // Reply frame
    localparam int REPLY_LEN  = 42;
    localparam int TX_MAX_LEN = 1500;
    localparam int RCNT_W     = $clog2(REPLY_LEN);
    localparam bit REPLY_FITS = (REPLY_LEN <= TX_MAX_LEN);

    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ARP_HW_ETHER = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
    localparam logic [7:0]  ARP_HW_LEN   = 8'd6;
    localparam logic [7:0]  ARP_PROTO_LEN = 8'd4;
    localparam logic [31:0] OWN_IP_RESET = 32'h0A00_0002;

    // Result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_ADVANCE = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 1;
    localparam int          CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b1;

    // Entry queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One finished ring entry, as handed to the back end
    typedef struct packed {
        logic [4:0]  status;     // status bits 0..4
        logic [15:0] length;
        logic [15:0] ethertype;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REPLY,
        BK_MOD,
        BK_REPORT
    } t_back_state;

endpackage

// ----- rtl/rra_in_if.sv -----
// Input byte channel of the responder.
interface rra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       entry_last;

    modport source (output valid, output data_byte, output entry_last, input ready);
    modport sink   (input valid, input data_byte, input entry_last, output ready);
endinterface

// ----- rtl/rra_out_if.sv -----
// Result channel of the responder.
interface rra_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [1:0]  reply_slot;
    logic [15:0] release_pointer;
    logic [3:0]  rx_error_bits;
    logic [15:0] frame_type;

    modport source (output valid, output result_kind, output reply_byte, output reply_last,
                    output reply_slot, output release_pointer, output rx_error_bits,
                    output frame_type, input ready);
    modport sink   (input valid, input result_kind, input reply_byte, input reply_last,
                    input reply_slot, input release_pointer, input rx_error_bits,
                    input frame_type, output ready);
endinterface

// ----- rtl/rx_ring_arp_responder.sv -----
// Top level of the receive-ring ARP responder: config registers, front, queue, back.
//
// The front end takes one ring entry byte per cycle and stalls only while the
// two-entry queue of finished entries is full. The back end works the queue in
// order: an accepted ARP entry takes 42 reply beats and an offset update,
// then one report beat; a rejected entry takes one report beat; other
// accepted entries wait on the compare-and-subtract loop that reduces the
// new ring offset modulo the ring size (up to 8 subtractions, hidden behind
// the reply burst for ARP frames). Results leave through an
// output register, one beat per cycle when the sink is ready. The station MAC
// and IP registers should be written only while no entry is in flight.
module rx_ring_arp_responder
    import rra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rra_in_if.sink                i_in,
    rra_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_job        push_job;
    t_job        head_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= OWN_IP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_MAC: r_own_mac <= i_cfg_wdata[47:0];
                CFG_OWN_IP:  r_own_ip  <= i_cfg_wdata[31:0];
                default:     ;
            endcase
        end
    end

    rra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    rra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .i_own_mac (r_own_mac),
        .i_own_ip  (r_own_ip),
        .o_out     (o_out)
    );

endmodule

// ----- rtl/rra_front.sv -----
// Front end: parses ring entry bytes and captures header and frame fields.
module rra_front
    import rra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    rra_in_if.sink  i_in,
    input  logic    i_q_full,
    output logic    o_push,
    output t_job    o_job
);

    logic [15:0] r_idx,    n_idx;
    logic [4:0]  r_status, n_status;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_etype,  n_etype;
    logic [47:0] r_mac,    n_mac;
    logic [31:0] r_ip,     n_ip;
    logic        beat;
    logic [7:0]  b;

    assign i_in.ready = !i_q_full;
    assign beat       = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // Field capture for the current byte; byte 0 clears the entry
    always_comb begin
        if (r_idx == 16'd0) begin
            n_status = '0;
            n_len    = '0;
            n_etype  = '0;
            n_mac    = '0;
            n_ip     = '0;
        end else begin
            n_status = r_status;
            n_len    = r_len;
            n_etype  = r_etype;
            n_mac    = r_mac;
            n_ip     = r_ip;
        end
        case (r_idx)
            16'd0:   n_status       = b[4:0];
            16'd2:   n_len[7:0]     = b;
            16'd3:   n_len[15:8]    = b;
            16'd16:  n_etype[15:8]  = b;
            16'd17:  n_etype[7:0]   = b;
            default: ;
        endcase
        // source MAC, frame bytes 6..11
        for (int k = 0; k < 6; k++) begin
            if (r_idx == 16'(10 + k)) n_mac[47 - 8*k -: 8] = b;
        end
        // frame bytes 28..31
        for (int k = 0; k < 4; k++) begin
            if (r_idx == 16'(32 + k)) n_ip[31 - 8*k -: 8] = b;
        end

        // byte counter saturates on very long entries
        if (i_in.entry_last)
            n_idx = '0;
        else if (r_idx != 16'hFFFF)
            n_idx = r_idx + 16'd1;
        else
            n_idx = r_idx;
    end

    assign o_push          = beat && i_in.entry_last;
    assign o_job.status    = n_status;
    assign o_job.length    = n_len;
    assign o_job.ethertype = n_etype;
    assign o_job.peer_mac  = n_mac;
    assign o_job.peer_ip   = n_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_status <= '0;
            r_len    <= '0;
            r_etype  <= '0;
            r_mac    <= '0;
            r_ip     <= '0;
        end else if (beat) begin
            r_idx    <= n_idx;
            r_status <= n_status;
            r_len    <= n_len;
            r_etype  <= n_etype;
            r_mac    <= n_mac;
            r_ip     <= n_ip;
        end
    end

endmodule

// ----- rtl/rra_queue.sv -----
// Small queue of finished entries between front and back end.
module rra_queue
    import rra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("entry queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("entry queue underflow");

endmodule

// ----- rtl/rra_back.sv -----
// Back end: sends ARP replies, advances the ring offset and reports each entry.
module rra_back
    import rra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_q_empty,
    output logic        o_pop,
    input  logic [47:0] i_own_mac,
    input  logic [31:0] i_own_ip,
    rra_out_if.source   o_out
);

    t_back_state       r_state, n_state;
    t_job              r_job,   n_job;
    logic [1:0]        r_kind,  n_kind;
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [RCNT_W-1:0] r_cnt,   n_cnt;
    logic [SLOT_W-1:0] r_slot,  n_slot;
    logic [OFS_W-1:0]  r_ofs,   n_ofs;

    // output register
    logic        r_ov,    n_ov;
    logic [1:0]  r_okind, n_okind;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic [1:0]  r_oslot, n_oslot;
    logic [15:0] r_orp,   n_orp;
    logic [3:0]  r_oerr,  n_oerr;
    logic [15:0] r_otype, n_otype;

    logic             out_free;
    logic             acc_ge;
    logic [ACC_W-1:0] acc_red;
    logic [ACC_W-1:0] load_acc;
    logic [15:0]      rp_full;
    logic             can_load;
    logic             reply_end;

    // Byte i of the ARP reply frame
    function automatic logic [7:0] reply_octet(input logic [RCNT_W-1:0] i,
                                               input logic [47:0] pm,
                                               input logic [47:0] om,
                                               input logic [31:0] oip,
                                               input logic [31:0] pip);
        logic [7:0] v;
        v = '0;
        case (i) inside
            [0:5]:   v = pm[47 - 8*i -: 8];
            [6:11]:  v = om[47 - 8*(i - 6) -: 8];
            12:      v = ETH_ARP[15:8];
            13:      v = ETH_ARP[7:0];
            14:      v = ARP_HW_ETHER[15:8];
            15:      v = ARP_HW_ETHER[7:0];
            16:      v = ETH_IPV4[15:8];
            17:      v = ETH_IPV4[7:0];
            18:      v = ARP_HW_LEN;
            19:      v = ARP_PROTO_LEN;
            20:      v = ARP_OP_REPLY[15:8];
            21:      v = ARP_OP_REPLY[7:0];
            [22:27]: v = om[47 - 8*(i - 22) -: 8];
            [28:31]: v = oip[31 - 8*(i - 28) -: 8];
            [32:37]: v = pm[47 - 8*(i - 32) -: 8];
            [38:41]: v = pip[31 - 8*(i - 38) -: 8];
            default: v = '0;
        endcase
        return v;
    endfunction

    assign out_free  = !r_ov || o_out.ready;
    assign acc_ge    = (r_acc >= ACC_W'(RING_MOD));
    assign acc_red   = acc_ge ? r_acc - ACC_W'(RING_MOD) : r_acc;
    assign load_acc  = (ACC_W'(r_ofs) + ACC_W'(i_job.length) + ACC_W'(7)) & ~ACC_W'(3);
    assign rp_full   = 16'(r_ofs) - 16'(RING_PAD);
    assign reply_end = (r_cnt == RCNT_W'(REPLY_LEN - 1));

    // Next state and beat generation
    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_slot   = r_slot;
        n_ofs    = r_ofs;
        n_ov     = r_ov && !o_out.ready;
        n_okind  = r_okind;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_oslot  = r_oslot;
        n_orp    = r_orp;
        n_oerr   = r_oerr;
        n_otype  = r_otype;
        o_pop    = 1'b0;
        can_load = 1'b0;

        case (r_state)
            BK_IDLE: begin
                can_load = 1'b1;
            end
            BK_REPLY: begin
                // offset reduction runs alongside the reply burst
                n_acc = acc_red;
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_REPLY;
                    n_obyte = reply_octet(r_cnt, r_job.peer_mac, i_own_mac,
                                          i_own_ip, r_job.peer_ip);
                    n_olast = reply_end;
                    n_oslot = r_slot;
                    n_orp   = '0;
                    n_oerr  = '0;
                    n_otype = '0;
                    if (reply_end) begin
                        n_slot  = (r_slot == SLOT_W'(TX_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                        n_state = BK_MOD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            BK_MOD: begin
                if (acc_ge) begin
                    n_acc = acc_red;
                end else begin
                    n_ofs   = r_acc[OFS_W-1:0];
                    n_state = BK_REPORT;
                end
            end
            BK_REPORT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_okind  = r_kind;
                    n_obyte  = '0;
                    n_olast  = 1'b0;
                    n_oslot  = '0;
                    n_orp    = rp_full;
                    n_oerr   = r_job.status[4:1];
                    n_otype  = r_job.ethertype;
                    n_state  = BK_IDLE;
                    can_load = 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // Take the next finished entry
        if (can_load && !i_q_empty) begin
            o_pop = 1'b1;
            n_job = i_job;
            n_acc = load_acc;
            n_cnt = '0;
            if (!i_job.status[0]) begin
                n_kind  = KIND_REJECT;
                n_state = BK_REPORT;
            end else if (i_job.ethertype == ETH_ARP && REPLY_FITS) begin
                n_kind  = KIND_ADVANCE;
                n_state = BK_REPLY;
            end else begin
                n_kind  = KIND_ADVANCE;
                n_state = BK_MOD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_slot  <= '0;
            r_ofs   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_ofs   <= n_ofs;
            r_ov    <= n_ov;
        end
    end

    // Entry and output payload
    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_kind  <= n_kind;
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_okind <= n_okind;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_oslot <= n_oslot;
        r_orp   <= n_orp;
        r_oerr  <= n_oerr;
        r_otype <= n_otype;
    end

    assign o_out.valid           = r_ov;
    assign o_out.result_kind     = r_okind;
    assign o_out.reply_byte      = r_obyte;
    assign o_out.reply_last      = r_olast;
    assign o_out.reply_slot      = r_oslot;
    assign o_out.release_pointer = r_orp;
    assign o_out.rx_error_bits   = r_oerr;
    assign o_out.frame_type      = r_otype;

    a_ofs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ofs) < RING_MOD)
        else $error("ring offset out of range");

    a_reply_arp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_REPLY |-> r_job.status[0] && r_job.ethertype == ETH_ARP)
        else $error("reply burst for a non-ARP or rejected entry");

endmodule

// ----- bench/rx_ring_arp_responder_test.sv -----
// Self-checking testbench for the receive-ring ARP responder: directed and random entries and stalls.
module rx_ring_arp_responder_test
    import rra_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          SETTLE_CYCLES = 16;

    // One result beat as the block presents it
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  rbyte;
        logic        rlast;
        logic [1:0]  slot;
        logic [15:0] rel_ptr;
        logic [3:0]  errs;
        logic [15:0] ftype;
    } t_ring_beat;

    // Receiver stall styles
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_MOSTLY
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rra_in_if  in_if();
    rra_out_if out_if();

    rx_ring_arp_responder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Station registers as last written
    logic [47:0] st_mac = '0;
    logic [31:0] st_ip  = OWN_IP_RESET;

    // Entry capture and ring state
    logic [15:0] cap_idx    = '0;
    logic [15:0] cap_status = '0;
    logic [15:0] cap_len    = '0;
    logic [15:0] cap_etype  = '0;
    logic [47:0] cap_mac    = '0;
    logic [31:0] cap_ip     = '0;
    int unsigned ring_ofs   = 0;
    int unsigned tx_slot    = 0;

    // Beats the block still owes, oldest first
    t_ring_beat owed_beats[$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_sent = 0;
    int          burst_left = 0;
    bit          sender_gaps = 1'b1;
    int          hold_asks = 0;

    // Receiver process state
    int       hold_seen = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    logic [7:0] stall_pattern = 8'h01;

    function automatic void owe(input logic [1:0] kind, input logic [7:0] rbyte,
                                input logic rlast, input logic [1:0] slot,
                                input logic [15:0] rel_ptr, input logic [3:0] errs,
                                input logic [15:0] ftype);
        t_ring_beat r;
        r = '{kind, rbyte, rlast, slot, rel_ptr, errs, ftype};
        owed_beats.push_back(r);
    endfunction

    // Fold one accepted ring byte into the capture state; queue the beats it causes
    task automatic take_ring_byte(input logic [7:0] b, input logic last);
        int unsigned k;
        int unsigned nxt;
        int          i;
        logic [REPLY_LEN*8-1:0] frame;
        logic [3:0]  errs;
        logic [15:0] rel;
        k = cap_idx;
        if (k == 0) begin
            cap_status = '0;
            cap_len    = '0;
            cap_mac    = '0;
            cap_etype  = '0;
            cap_ip     = '0;
        end
        if (k == 0) cap_status[7:0] = b;
        else if (k == 1) cap_status[15:8] = b;
        else if (k == 2) cap_len[7:0] = b;
        else if (k == 3) cap_len[15:8] = b;
        else if (k >= 10 && k < 16) cap_mac[47 - 8*(k-10) -: 8] = b;
        else if (k == 16) cap_etype[15:8] = b;
        else if (k == 17) cap_etype[7:0] = b;
        else if (k >= 32 && k < 36) cap_ip[31 - 8*(k-32) -: 8] = b;

        if (!last) begin
            if (cap_idx != 16'hFFFF) cap_idx++;
            return;
        end
        cap_idx = '0;
        errs = cap_status[4:1];

        // rejected entry: offset and slot stay put
        if (!cap_status[0]) begin
            rel = ring_ofs[15:0] - 16'(RING_PAD);
            owe(KIND_REJECT, 8'd0, 1'b0, 2'd0, rel, errs, cap_etype);
            return;
        end

        // ARP reply burst ahead of the report
        if (cap_etype == ETH_ARP && REPLY_FITS) begin
            frame = {cap_mac, st_mac, ETH_ARP, ARP_HW_ETHER, ETH_IPV4, ARP_HW_LEN,
                     ARP_PROTO_LEN, ARP_OP_REPLY, st_mac, st_ip, cap_mac, cap_ip};
            for (i = 0; i < REPLY_LEN; i++)
                owe(KIND_REPLY, frame[REPLY_LEN*8-1 - 8*i -: 8], i == REPLY_LEN - 1,
                    2'(tx_slot), 16'd0, 4'd0, 16'd0);
            tx_slot = (tx_slot + 1) % TX_SLOTS;
        end

        // advance by header length plus 4, rounded up to 4, wrapped modulo the ring size
        nxt = (ring_ofs + cap_len + 7) & ~32'd3;
        ring_ofs = nxt % RING_MOD;
        rel = ring_ofs[15:0] - 16'(RING_PAD);
        owe(KIND_ADVANCE, 8'd0, 1'b0, 2'd0, rel, errs, cap_etype);
    endtask

    // Offer one byte beat, with burst gaps, and wait for the handshake
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 40);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.entry_last <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        beats_sent++;
        take_ring_byte(b, last);
    endtask

    // Stream one ring entry; filler < 0 means random payload bytes
    task automatic ring_entry(input logic [15:0] status, input logic [15:0] hdr_len,
                              input logic [15:0] etype, input logic [47:0] src_mac,
                              input logic [31:0] src_ip, input int nbytes, input int filler);
        int k;
        logic [31:0] hdr;
        logic [7:0]  b;
        hdr = {hdr_len, status};
        for (k = 0; k < nbytes; k++) begin
            if (k < 4) b = hdr[8*k +: 8];
            else if (k >= 10 && k < 16) b = src_mac[47 - 8*(k-10) -: 8];
            else if (k == 16) b = etype[15:8];
            else if (k == 17) b = etype[7:0];
            else if (k >= 32 && k < 36) b = src_ip[31 - 8*(k-32) -: 8];
            else if (filler < 0) b = 8'($urandom);
            else b = 8'(filler);
            send_beat(b, k == nbytes - 1);
        end
    endtask

    // Stop offering, let every owed beat arrive, then let the back end go quiet
    task automatic settle_idle();
        in_if.valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_OWN_MAC) st_mac = val;
        else if (idx == CFG_OWN_IP) st_ip = val[31:0];
    endtask

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    // Register reset values; a rejected entry at offset zero reports below the pad
    task automatic test_reset_defaults();
        ring_entry(16'h0000, 16'd0, 16'd0, '0, '0, 1, -1);
        ring_entry(16'h0001, 16'd42, ETH_ARP, 48'h0200_0000_0001, 32'h0A00_0001, 36, -1);
        settle_idle();
    endtask

    // Short, rejected, mismatched and extreme entries
    task automatic test_entry_cases();
        // one byte only: length counts as zero, fields cleared at entry start
        ring_entry(16'h0001, 16'd0, 16'd0, '0, '0, 1, -1);
        // header cut inside the length field, error bits set
        ring_entry(16'h001F, 16'h00FF, 16'd0, '0, '0, 3, -1);
        // rejected with all error bits, ARP type but no reply, slot kept
        ring_entry(16'hFFFE, 16'd42, ETH_ARP, rand_mac(), $urandom, 18, -1);
        // all ones everywhere, largest header length
        ring_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, 18, 255);
        // header length disagrees with bytes streamed; byte-swapped ARP type is not ARP
        ring_entry(16'h0009, 16'd1500, 16'h0608, rand_mac(), $urandom, 18, -1);
        // rounding of a one-byte length
        ring_entry(16'h0001, 16'd1, ETH_IPV4, '0, '0, 4, -1);
        settle_idle();
    endtask

    // Station registers at their extremes; ARP entry cut before the sender IP
    task automatic test_station_regs();
        write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_OWN_IP, 48'h0);
        ring_entry(16'h0001 | 16'($urandom_range(0, 15) << 1), 16'($urandom_range(28, 64)),
                   ETH_ARP, rand_mac(), $urandom, 18, -1);
        settle_idle();
    endtask

    // Long receiver hold-off while the sender keeps pushing: input must stall.
    // The replies here also carry the slot counter past its wrap.
    task automatic test_backpressure();
        int e;
        sender_gaps = 1'b0;
        hold_asks++;
        for (e = 0; e < 3; e++)
            ring_entry(16'h0001, 16'd42, ETH_ARP, rand_mac(), $urandom, 18, -1);
        ring_entry(16'h0001, 16'd0, 16'd0, '0, '0, 1, -1);
        sender_gaps = 1'b1;
        settle_idle();
    endtask

    // One random entry: mostly ARP, the rest noise and broken entries
    task automatic random_entry();
        int          pick;
        logic [15:0] st;
        logic [15:0] len;
        logic [15:0] et;
        pick = $urandom_range(0, 9);
        st   = 16'($urandom);
        len  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(28, 64));
        et   = ($urandom_range(0, 1) == 1) ? ETH_IPV4 : 16'($urandom);
        case (pick)
            0, 1, 2, 3, 4, 5: begin
                st[0] = 1'b1;
                ring_entry(st, len, ETH_ARP, rand_mac(), $urandom, $urandom_range(18, 36), -1);
            end
            6: begin
                st[0] = 1'b1;
                ring_entry(st, len, et, rand_mac(), $urandom, $urandom_range(4, 24), -1);
            end
            7: begin
                st[0] = 1'b0;
                ring_entry(st, len, ($urandom_range(0, 1) == 1) ? ETH_ARP : et, rand_mac(),
                           $urandom, $urandom_range(1, 24), -1);
            end
            8: ring_entry(st, len, et, rand_mac(), $urandom, $urandom_range(1, 17), -1);
            default: begin
                st[0] = 1'b1;
                ring_entry(st, 16'($urandom), ETH_ARP, rand_mac(), $urandom,
                           $urandom_range(14, 35), -1);
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int budget_end;
        write_reg(CFG_OWN_MAC, rand_mac());
        write_reg(CFG_OWN_IP, 48'($urandom));
        budget_end = beats_sent + 10;
        while (beats_sent < budget_end) random_entry();
        settle_idle();
    endtask

    // Receiver: requested hold-off first, else a stall style that changes now and then
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                    stall_pattern = 8'($urandom) | 8'h01;
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS:  out_if.ready <= 1'b1;
                    RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: begin
                        out_if.ready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                    default:    out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic void match_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result beat with the oldest owed one
    always @(posedge i_clk) begin
        t_ring_beat want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (owed_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected, kind %h", $time,
                         out_if.result_kind);
                mismatches++;
            end else begin
                want = owed_beats.pop_front();
                match_field("result_kind", want.kind, out_if.result_kind);
                match_field("reply_byte", want.rbyte, out_if.reply_byte);
                match_field("reply_last", want.rlast, out_if.reply_last);
                match_field("reply_slot", want.slot, out_if.reply_slot);
                match_field("release_pointer", want.rel_ptr, out_if.release_pointer);
                match_field("rx_error_bits", want.errs, out_if.rx_error_bits);
                match_field("frame_type", want.ftype, out_if.frame_type);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rx_ring_arp_responder verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'd0;
        in_if.entry_last <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_OWN_MAC;
        i_cfg_wdata      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_entry_cases();
        test_station_regs();
        test_backpressure();
        test_random_traffic();

        if (mismatches == 0) begin
            $display("rx_ring_arp_responder verification clean");
        end else begin
            $display("rx_ring_arp_responder verification failed");
        end
        $finish;
    end

endmodule
